// ----- hdl/ttb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants for the triangle tangent basis block
// Corner codes, field widths, the fixed-point shift and the MAC request type.
// ----------------------------------------------------------------------------
package ttb_pkg;

	localparam int POS_WIDTH_DEF = 16;
	localparam int OUT_WIDTH_DEF = 32;
	localparam int TEX_WIDTH     = 16;

	// numerator is in 2^-20 units, determinant in 2^-24; one extra bit for rounding
	localparam int FRAC_SHIFT = 21;

	localparam logic [1:0] CORNER_FIRST  = 2'd0;
	localparam logic [1:0] CORNER_SECOND = 2'd1;
	localparam logic [1:0] CORNER_LAST   = 2'd2;

	typedef enum logic {
		MAC_LOAD,
		MAC_SUB
	} mac_op_t;

	typedef struct packed {
		logic    issue;
		mac_op_t op;
	} mac_req_t;

endpackage

// ----- hdl/ttb_mac.sv -----
// ----------------------------------------------------------------------------
// ttb_mac: shared multiply-accumulate unit
// Registered signed multiply, then load or subtract into the accumulator.
// ----------------------------------------------------------------------------
module ttb_mac import ttb_pkg::*; #(
	parameter int AW = 17,
	parameter int BW = 17,
	parameter int NW = 35
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mac_req_t             req,
	input  logic signed [AW-1:0] op_a,
	input  logic signed [BW-1:0] op_b,
	output logic signed [NW-1:0] acc
);

	localparam int PW = AW + BW;

	logic                 vld_s1;
	mac_op_t              op_s1;
	logic signed [PW-1:0] prod_s1;
	logic signed [NW-1:0] prod_ext;
	logic signed [NW-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.issue;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= req.op;
		prod_s1 <= op_a * op_b;
		if (vld_s1) begin
			if (op_s1 == MAC_LOAD) begin
				acc_q <= prod_ext;
			end else begin
				acc_q <= acc_q - prod_ext;
			end
		end
	end

	assign prod_ext = {{(NW-PW){prod_s1[PW-1]}}, prod_s1};
	assign acc      = acc_q;

endmodule

// ----- hdl/ttb_div.sv -----
// ----------------------------------------------------------------------------
// ttb_div: serial divider with rounding and saturation
// Computes round(num * 2^20 / den), half away from zero, one quotient bit per
// cycle, and clamps to the signed OW-bit range.
// ----------------------------------------------------------------------------
module ttb_div import ttb_pkg::*; #(
	parameter int NW = 35,
	parameter int OW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic signed [NW-1:0] den,
	output logic                 done,
	output logic signed [OW-1:0] quot
);

	localparam int EXW = NW + FRAC_SHIFT + OW + 1;
	localparam int CW  = $clog2(OW + 2);
	localparam logic [OW:0] LIMIT   = (OW+1)'(1) << (OW - 1);
	localparam logic [OW:0] POS_MAX = LIMIT - (OW+1)'(1);

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_PREP,
		DV_ITER,
		DV_FIN
	} dv_state_t;

	dv_state_t           state_q;
	logic [NW-1:0]       an_q;
	logic [NW-1:0]       ad_q;
	logic                neg_q;
	logic                sat_q;
	logic [NW-1:0]       rem_q;
	logic [OW:0]         lo_q;
	logic [OW:0]         q_q;
	logic [CW-1:0]       cnt_q;
	logic                done_q;
	logic signed [OW-1:0] quot_q;

	logic [NW-1:0]  num_mag;
	logic [NW-1:0]  den_mag;
	logic [EXW-1:0] ext;
	logic [EXW-1:0] hi;
	logic           sat_d;
	logic [NW:0]    trial;
	logic [NW:0]    diff;
	logic           fits;
	logic [OW+1:0]  rnd;
	logic [OW:0]    mag;
	logic [OW:0]    sel_mag;
	logic [OW:0]    neg_mag;
	logic [OW-1:0]  quot_d;

	always_comb begin
		num_mag = num[NW-1] ? (NW'(0) - num) : num;
		den_mag = den[NW-1] ? (NW'(0) - den) : den;
		ext     = EXW'(an_q) << FRAC_SHIFT;
		hi      = ext >> (OW + 1);
		sat_d   = hi >= EXW'(ad_q);
		trial   = {rem_q, lo_q[OW]};
		fits    = trial >= {1'b0, ad_q};
		diff    = trial - {1'b0, ad_q};
		rnd     = {1'b0, q_q} + (OW+2)'(1);
		mag     = rnd[OW+1:1];
		if (neg_q) begin
			sel_mag = (sat_q || mag > LIMIT) ? LIMIT : mag;
		end else begin
			sel_mag = (sat_q || mag > POS_MAX) ? POS_MAX : mag;
		end
		neg_mag = (OW+1)'(0) - sel_mag;
		quot_d  = neg_q ? neg_mag[OW-1:0] : sel_mag[OW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			an_q    <= '0;
			ad_q    <= '0;
			neg_q   <= 1'b0;
			sat_q   <= 1'b0;
			rem_q   <= '0;
			lo_q    <= '0;
			q_q     <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			quot_q  <= '0;
		end else begin
			done_q <= (state_q == DV_FIN);
			case (state_q)
				DV_IDLE: begin
					if (start) begin
						an_q    <= num_mag;
						ad_q    <= den_mag;
						neg_q   <= num[NW-1] ^ den[NW-1];
						state_q <= DV_PREP;
					end
				end
				DV_PREP: begin
					// preload the remainder with the high part; the rest shifts in
					sat_q   <= sat_d;
					rem_q   <= hi[NW-1:0];
					lo_q    <= ext[OW:0];
					q_q     <= '0;
					cnt_q   <= CW'(OW + 1);
					state_q <= sat_d ? DV_FIN : DV_ITER;
				end
				DV_ITER: begin
					rem_q <= fits ? diff[NW-1:0] : trial[NW-1:0];
					q_q   <= {q_q[OW-1:0], fits};
					lo_q  <= {lo_q[OW-1:0], 1'b0};
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= DV_FIN;
					end
				end
				DV_FIN: begin
					quot_q  <= quot_d;
					state_q <= DV_IDLE;
				end
				default: begin
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- hdl/triangle_tangent_basis.sv -----
// ----------------------------------------------------------------------------
// triangle_tangent_basis: per-triangle tangent and bitangent from UVs
// Usage:
//   Vertex channel (vtx_*) takes one corner per transfer. Corners 0 and 1 are
//   held; corner 2 completes the triangle and starts the computation. Corner
//   code 3 is dropped. A held corner stays until overwritten.
//   Result channel (res_*) gives one transfer per corner 2: tangent and
//   bitangent in signed Q15.16, saturated, plus a degenerate flag when the UV
//   determinant is zero (vectors then zero).
// Timing:
//   Corners 0 and 1 leave vtx_ready high. Corner 2 keeps vtx_ready low until
//   the result register is loaded, for less time when quotients saturate or
//   the triangle is degenerate. The cost is set by the serial divider, one
//   quotient bit per cycle for each of six components; the fourteen products
//   share one multiply-accumulate unit.
//   The result register holds one finished triangle; corners 0 and 1 are
//   taken while it waits, and a new triangle waits for the register to free.
// Reset:
//   arst_n clears the held corners to zero and drops res_valid.
// ----------------------------------------------------------------------------
module triangle_tangent_basis import ttb_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vtx_valid,
	output logic                        vtx_ready,
	input  logic [1:0]                  corner,
	input  logic signed [POS_WIDTH-1:0] pos_x,
	input  logic signed [POS_WIDTH-1:0] pos_y,
	input  logic signed [POS_WIDTH-1:0] pos_z,
	input  logic signed [TEX_WIDTH-1:0] tex_u,
	input  logic signed [TEX_WIDTH-1:0] tex_v,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic signed [OUT_WIDTH-1:0] tangent_x,
	output logic signed [OUT_WIDTH-1:0] tangent_y,
	output logic signed [OUT_WIDTH-1:0] tangent_z,
	output logic signed [OUT_WIDTH-1:0] bitangent_x,
	output logic signed [OUT_WIDTH-1:0] bitangent_y,
	output logic signed [OUT_WIDTH-1:0] bitangent_z,
	output logic                        degenerate
);

	localparam int EW = POS_WIDTH + 1;
	localparam int DW = TEX_WIDTH + 1;
	localparam int MB = (EW > DW) ? EW : DW;
	localparam int NW = MB + DW + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_DRAIN,
		ST_EVAL,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		JOB_DET,
		JOB_TX,
		JOB_TY,
		JOB_TZ,
		JOB_BX,
		JOB_BY,
		JOB_BZ
	} job_t;

	state_t state_q;
	job_t   job_q;

	logic signed [POS_WIDTH-1:0] hpos_q [0:1][0:2];
	logic signed [TEX_WIDTH-1:0] htex_q [0:1][0:1];
	logic signed [EW-1:0]        e1_q [0:2];
	logic signed [EW-1:0]        e2_q [0:2];
	logic signed [DW-1:0]        d1u_q;
	logic signed [DW-1:0]        d1v_q;
	logic signed [DW-1:0]        d2u_q;
	logic signed [DW-1:0]        d2v_q;
	logic signed [NW-1:0]        det_q;
	logic                        degen_q;
	logic signed [OUT_WIDTH-1:0] res_q [0:5];
	logic                        div_start_q;

	logic                        res_valid_q;
	logic signed [OUT_WIDTH-1:0] tangent_x_q;
	logic signed [OUT_WIDTH-1:0] tangent_y_q;
	logic signed [OUT_WIDTH-1:0] tangent_z_q;
	logic signed [OUT_WIDTH-1:0] bitangent_x_q;
	logic signed [OUT_WIDTH-1:0] bitangent_y_q;
	logic signed [OUT_WIDTH-1:0] bitangent_z_q;
	logic                        degenerate_q;

	mac_req_t                    mac_req;
	logic signed [DW-1:0]        op_a;
	logic signed [MB-1:0]        op_b;
	logic signed [EW-1:0]        e1_sel;
	logic signed [EW-1:0]        e2_sel;
	logic                        ph_a;
	logic signed [NW-1:0]        acc;
	logic                        div_done;
	logic signed [OUT_WIDTH-1:0] quot;

	// operand select: every job is a*b - c*d over two MAC slots
	always_comb begin
		ph_a = (state_q == ST_MUL_A);
		case (job_q)
			JOB_TX, JOB_BX: begin
				e1_sel = e1_q[0];
				e2_sel = e2_q[0];
			end
			JOB_TY, JOB_BY: begin
				e1_sel = e1_q[1];
				e2_sel = e2_q[1];
			end
			default: begin
				e1_sel = e1_q[2];
				e2_sel = e2_q[2];
			end
		endcase
		case (job_q)
			JOB_TX, JOB_TY, JOB_TZ: begin
				op_a = ph_a ? d2v_q : d1v_q;
				op_b = ph_a ? MB'(e1_sel) : MB'(e2_sel);
			end
			JOB_BX, JOB_BY, JOB_BZ: begin
				op_a = ph_a ? d1u_q : d2u_q;
				op_b = ph_a ? MB'(e2_sel) : MB'(e1_sel);
			end
			default: begin
				op_a = ph_a ? d1u_q : d2u_q;
				op_b = ph_a ? MB'(d2v_q) : MB'(d1v_q);
			end
		endcase
		mac_req.issue = (state_q == ST_MUL_A) || (state_q == ST_MUL_B);
		mac_req.op    = ph_a ? MAC_LOAD : MAC_SUB;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			job_q         <= JOB_DET;
			div_start_q   <= 1'b0;
			degen_q       <= 1'b0;
			det_q         <= '0;
			d1u_q         <= '0;
			d1v_q         <= '0;
			d2u_q         <= '0;
			d2v_q         <= '0;
			for (int i = 0; i < 2; i++) begin
				for (int k = 0; k < 3; k++) begin
					hpos_q[i][k] <= '0;
				end
				htex_q[i][0] <= '0;
				htex_q[i][1] <= '0;
			end
			for (int k = 0; k < 3; k++) begin
				e1_q[k] <= '0;
				e2_q[k] <= '0;
			end
			for (int j = 0; j < 6; j++) begin
				res_q[j] <= '0;
			end
			res_valid_q   <= 1'b0;
			tangent_x_q   <= '0;
			tangent_y_q   <= '0;
			tangent_z_q   <= '0;
			bitangent_x_q <= '0;
			bitangent_y_q <= '0;
			bitangent_z_q <= '0;
			degenerate_q  <= 1'b0;
		end else begin
			// kick the divider once per vector component
			div_start_q <= (state_q == ST_EVAL) && (job_q != JOB_DET);
			// ST_OUT reloads the result register itself
			if (res_valid_q && res_ready && state_q != ST_OUT) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (vtx_valid) begin
						if (corner == CORNER_FIRST || corner == CORNER_SECOND) begin
							hpos_q[corner[0]][0] <= pos_x;
							hpos_q[corner[0]][1] <= pos_y;
							hpos_q[corner[0]][2] <= pos_z;
							htex_q[corner[0]][0] <= tex_u;
							htex_q[corner[0]][1] <= tex_v;
						end else if (corner == CORNER_LAST) begin
							e1_q[0] <= EW'(hpos_q[1][0]) - EW'(hpos_q[0][0]);
							e1_q[1] <= EW'(hpos_q[1][1]) - EW'(hpos_q[0][1]);
							e1_q[2] <= EW'(hpos_q[1][2]) - EW'(hpos_q[0][2]);
							e2_q[0] <= EW'(pos_x) - EW'(hpos_q[0][0]);
							e2_q[1] <= EW'(pos_y) - EW'(hpos_q[0][1]);
							e2_q[2] <= EW'(pos_z) - EW'(hpos_q[0][2]);
							d1u_q   <= DW'(htex_q[1][0]) - DW'(htex_q[0][0]);
							d1v_q   <= DW'(htex_q[1][1]) - DW'(htex_q[0][1]);
							d2u_q   <= DW'(tex_u) - DW'(htex_q[0][0]);
							d2v_q   <= DW'(tex_v) - DW'(htex_q[0][1]);
							job_q   <= JOB_DET;
							state_q <= ST_MUL_A;
						end
					end
				end
				ST_MUL_A: begin
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (job_q == JOB_DET) begin
						if (acc == '0) begin
							degen_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							det_q   <= acc;
							degen_q <= 1'b0;
							job_q   <= JOB_TX;
							state_q <= ST_MUL_A;
						end
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						// components arrive in output order; shift them toward slot 0
						for (int j = 0; j < 5; j++) begin
							res_q[j] <= res_q[j+1];
						end
						res_q[5] <= quot;
						if (job_q == JOB_BZ) begin
							state_q <= ST_OUT;
						end else begin
							job_q   <= job_t'(job_q + 3'd1);
							state_q <= ST_MUL_A;
						end
					end
				end
				ST_OUT: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q   <= 1'b1;
						tangent_x_q   <= degen_q ? '0 : res_q[0];
						tangent_y_q   <= degen_q ? '0 : res_q[1];
						tangent_z_q   <= degen_q ? '0 : res_q[2];
						bitangent_x_q <= degen_q ? '0 : res_q[3];
						bitangent_y_q <= degen_q ? '0 : res_q[4];
						bitangent_z_q <= degen_q ? '0 : res_q[5];
						degenerate_q  <= degen_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	ttb_mac #(
		.AW (DW),
		.BW (MB),
		.NW (NW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (acc)
	);

	ttb_div #(
		.NW (NW),
		.OW (OUT_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (acc),
		.den    (det_q),
		.done   (div_done),
		.quot   (quot)
	);

	assign vtx_ready   = (state_q == ST_IDLE);
	assign res_valid   = res_valid_q;
	assign tangent_x   = tangent_x_q;
	assign tangent_y   = tangent_y_q;
	assign tangent_z   = tangent_z_q;
	assign bitangent_x = bitangent_x_q;
	assign bitangent_y = bitangent_y_q;
	assign bitangent_z = bitangent_z_q;
	assign degenerate  = degenerate_q;

endmodule

// ----- hdl/ttb_chk.sv -----
// ----------------------------------------------------------------------------
// ttb_chk: port-level checks for the triangle tangent basis block
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module ttb_chk import ttb_pkg::*; #(
	parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        vtx_valid,
	input logic                        vtx_ready,
	input logic [1:0]                  corner,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic signed [OUT_WIDTH-1:0] tangent_x,
	input logic signed [OUT_WIDTH-1:0] tangent_y,
	input logic signed [OUT_WIDTH-1:0] tangent_z,
	input logic signed [OUT_WIDTH-1:0] bitangent_x,
	input logic signed [OUT_WIDTH-1:0] bitangent_y,
	input logic signed [OUT_WIDTH-1:0] bitangent_z,
	input logic                        degenerate
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(tangent_x) &&
		$stable(tangent_y) && $stable(tangent_z) && $stable(bitangent_x) &&
		$stable(bitangent_y) && $stable(bitangent_z) && $stable(degenerate))
		else $error("result changed while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && degenerate |-> tangent_x == '0 && tangent_y == '0 &&
		tangent_z == '0 && bitangent_x == '0 && bitangent_y == '0 &&
		bitangent_z == '0)
		else $error("degenerate result carries nonzero vectors");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && vtx_ready && corner == CORNER_LAST |=> !vtx_ready)
		else $error("vertex channel ready right after a closing corner");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(vtx_ready))
		else $error("result appeared without a triangle in progress");

endmodule

bind triangle_tangent_basis ttb_chk #(
	.OUT_WIDTH (OUT_WIDTH)
) u_ttb_chk (.*);

// ----- sim/triangle_tangent_basis_tb.sv -----
// ----------------------------------------------------------------------------
// triangle_tangent_basis_tb: self-checking bench for the tangent basis block
// Streams triangle corners over the vertex channel and rebuilds every tangent
// and bitangent in a bit-exact fixed-point predictor. It starts with a short
// list of hand-picked corners, then runs random triangles and noise under
// four idling mixes. It also holds the result channel off long enough for the
// vertex channel to back up.
// ----------------------------------------------------------------------------
module triangle_tangent_basis_tb;
	import ttb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CORNER_UNUSED = 2'd3;
	localparam int         HOLD_CYCLES   = 600;
	localparam int         DRAIN_CYCLES  = 300;
	localparam int         RANDOM_ITEMS  = 420;

	typedef struct packed {
		logic [1:0]               corner;
		logic [POS_WIDTH_DEF-1:0] pos_x;
		logic [POS_WIDTH_DEF-1:0] pos_y;
		logic [POS_WIDTH_DEF-1:0] pos_z;
		logic [TEX_WIDTH-1:0]     tex_u;
		logic [TEX_WIDTH-1:0]     tex_v;
	} vertex_t;

	// vec[0..2] tangent x, y, z; vec[3..5] bitangent x, y, z
	typedef struct packed {
		logic [5:0][OUT_WIDTH_DEF-1:0] vec;
		logic                          degenerate;
	} frame_t;

	typedef struct packed {
		vertex_t vtx;
		logic    typed;
		frame_t  want;
	} stim_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            vtx_valid;
	logic                            vtx_ready;
	logic [1:0]                      corner;
	logic signed [POS_WIDTH_DEF-1:0] pos_x;
	logic signed [POS_WIDTH_DEF-1:0] pos_y;
	logic signed [POS_WIDTH_DEF-1:0] pos_z;
	logic signed [TEX_WIDTH-1:0]     tex_u;
	logic signed [TEX_WIDTH-1:0]     tex_v;
	logic                            res_valid;
	logic                            res_ready = 1'b0;
	logic signed [OUT_WIDTH_DEF-1:0] tangent_x;
	logic signed [OUT_WIDTH_DEF-1:0] tangent_y;
	logic signed [OUT_WIDTH_DEF-1:0] tangent_z;
	logic signed [OUT_WIDTH_DEF-1:0] bitangent_x;
	logic signed [OUT_WIDTH_DEF-1:0] bitangent_y;
	logic signed [OUT_WIDTH_DEF-1:0] bitangent_z;
	logic                            degenerate;

	// predictor copy of the held corners
	logic signed [POS_WIDTH_DEF-1:0] held_pos [0:1][0:2];
	logic signed [TEX_WIDTH-1:0]     held_uv  [0:1][0:1];

	frame_t    pending_frames [$];
	stim_row_t stim_rows [$];

	int gap_pct;
	int stall_pct;
	int hold_req;
	int hold_left;
	int vertices_taken;
	int drops_taken;
	int results_seen;
	int degenerate_seen;
	int saturated_seen;
	int mismatches;

	triangle_tangent_basis dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.vtx_valid   (vtx_valid),
		.vtx_ready   (vtx_ready),
		.corner      (corner),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.tangent_x   (tangent_x),
		.tangent_y   (tangent_y),
		.tangent_z   (tangent_z),
		.bitangent_x (bitangent_x),
		.bitangent_y (bitangent_y),
		.bitangent_z (bitangent_z),
		.degenerate  (degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d results still pending", pending_frames.size());
		$display("** triangle_tangent_basis: FAILED **");
		$finish;
	end

	// N * 2^20 / D, rounded half away from zero, saturated to the output width
	function automatic logic [OUT_WIDTH_DEF-1:0] q15_16_quotient(longint n, longint d);
		longint unsigned an, ad, qi, r, q, mag, lim;
		bit              neg, sat;
		lim = 64'd1 << (OUT_WIDTH_DEF - 1);
		neg = (n < 0) != (d < 0);
		an  = (n < 0) ? -n : n;
		ad  = (d < 0) ? -d : d;
		qi  = an / ad;
		r   = an % ad;
		sat = qi > (lim >> (FRAC_SHIFT - 1));
		mag = 0;
		if (!sat) begin
			q   = (qi << FRAC_SHIFT) + (r << FRAC_SHIFT) / ad;
			mag = (q + 1) >> 1;
		end
		if (neg) begin
			if (sat || mag > lim)
				mag = lim;
			mag = -mag;
		end else if (sat || mag > lim - 1) begin
			mag = lim - 1;
		end
		return mag[OUT_WIDTH_DEF-1:0];
	endfunction

	// Update the held corners; return 1 with the frame when a triangle closes.
	function automatic bit absorb_vertex(input vertex_t v, output frame_t f);
		longint p[3], e1[3], e2[3];
		longint d1u, d1v, d2u, d2v, det;
		int     k;
		f    = '0;
		p[0] = longint'($signed(v.pos_x));
		p[1] = longint'($signed(v.pos_y));
		p[2] = longint'($signed(v.pos_z));
		if (v.corner == CORNER_FIRST || v.corner == CORNER_SECOND) begin
			held_pos[v.corner[0]][0] = v.pos_x;
			held_pos[v.corner[0]][1] = v.pos_y;
			held_pos[v.corner[0]][2] = v.pos_z;
			held_uv[v.corner[0]][0]  = v.tex_u;
			held_uv[v.corner[0]][1]  = v.tex_v;
			return 1'b0;
		end
		if (v.corner != CORNER_LAST)
			return 1'b0;
		for (k = 0; k < 3; k++) begin
			e1[k] = longint'(held_pos[1][k]) - longint'(held_pos[0][k]);
			e2[k] = p[k] - longint'(held_pos[0][k]);
		end
		d1u = longint'(held_uv[1][0]) - longint'(held_uv[0][0]);
		d1v = longint'(held_uv[1][1]) - longint'(held_uv[0][1]);
		d2u = longint'($signed(v.tex_u)) - longint'(held_uv[0][0]);
		d2v = longint'($signed(v.tex_v)) - longint'(held_uv[0][1]);
		det = d1u * d2v - d2u * d1v;
		if (det == 0) begin
			f.degenerate = 1'b1;
			return 1'b1;
		end
		for (k = 0; k < 3; k++) begin
			f.vec[k]     = q15_16_quotient(d2v * e1[k] - d1v * e2[k], det);
			f.vec[3 + k] = q15_16_quotient(d1u * e2[k] - d2u * e1[k], det);
		end
		return 1'b1;
	endfunction

	function automatic frame_t frame_of(logic [OUT_WIDTH_DEF-1:0] tx, logic deg);
		frame_t f;
		f            = '0;
		f.vec[0]     = tx;
		f.degenerate = deg;
		return f;
	endfunction

	function automatic logic [15:0] near_zero(int span);
		return 16'(int'($urandom_range(2 * span)) - span);
	endfunction

	task automatic add_row(input logic [1:0] c, input logic [15:0] x, y, z, u, v,
			input logic typed, input frame_t want);
		stim_row_t row;
		row.vtx   = '{c, x, y, z, u, v};
		row.typed = typed;
		row.want  = want;
		stim_rows.insert(stim_rows.size(), row);
	endtask

	task automatic flag_error(input string what, input logic [31:0] exp_val, act_val);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %h, got %h", $realtime, what, exp_val, act_val);
	endtask

	// Offer one corner and hold it until the vertex channel takes it.
	task automatic offer_vertex(input vertex_t v);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			vtx_valid <= 1'b0;
		end
		@(negedge clk);
		vtx_valid <= 1'b1;
		corner    <= v.corner;
		pos_x     <= v.pos_x;
		pos_y     <= v.pos_y;
		pos_z     <= v.pos_z;
		tex_u     <= v.tex_u;
		tex_v     <= v.tex_v;
		do @(posedge clk); while (!vtx_ready);
	endtask

	task automatic take_vertex(input vertex_t v, input logic typed, input frame_t want);
		frame_t f;
		offer_vertex(v);
		if (v.corner == CORNER_UNUSED)
			drops_taken++;
		else
			vertices_taken++;
		if (absorb_vertex(v, f))
			pending_frames.insert(pending_frames.size(), typed ? want : f);
	endtask

	function automatic vertex_t random_vertex(logic [1:0] c, bit wide);
		vertex_t v;
		v.corner = c;
		v.pos_x  = wide ? 16'($urandom) : near_zero(1024);
		v.pos_y  = wide ? 16'($urandom) : near_zero(1024);
		v.pos_z  = wide ? 16'($urandom) : near_zero(1024);
		v.tex_u  = wide ? 16'($urandom) : near_zero(4096);
		v.tex_v  = wide ? 16'($urandom) : near_zero(4096);
		return v;
	endfunction

	task automatic send_triangle();
		vertex_t     corners [3];
		int          style;
		logic [15:0] du, dv;
		int          k;
		style      = $urandom_range(99);
		corners[0] = random_vertex(CORNER_FIRST, style < 50);
		corners[1] = random_vertex(CORNER_SECOND, style < 50);
		corners[2] = random_vertex(CORNER_LAST, style < 50);
		if (style >= 75 && style < 88) begin
			// tiny UV deltas: small determinant, mostly saturating quotients
			corners[1].tex_u = corners[0].tex_u + near_zero(3);
			corners[1].tex_v = corners[0].tex_v + near_zero(3);
			corners[2].tex_u = corners[0].tex_u + near_zero(3);
			corners[2].tex_v = corners[0].tex_v + near_zero(3);
		end else if (style >= 88) begin
			case ($urandom_range(2))
				0: begin
					corners[2].tex_u = corners[0].tex_u;
					corners[2].tex_v = corners[0].tex_v;
				end
				1: begin
					corners[1].tex_u = corners[0].tex_u;
					corners[1].tex_v = corners[0].tex_v;
				end
				default: begin
					du               = near_zero(2000);
					dv               = near_zero(2000);
					corners[1].tex_u = corners[0].tex_u + du;
					corners[1].tex_v = corners[0].tex_v + dv;
					corners[2].tex_u = corners[0].tex_u + (du << 1);
					corners[2].tex_v = corners[0].tex_v + (dv << 1);
				end
			endcase
		end
		for (k = 0; k < 3; k++)
			take_vertex(corners[k], 1'b0, '0);
	endtask

	// result channel: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		frame_t got, want;
		int     k;
		bit     clipped;
		if (arst_n && res_valid && res_ready) begin
			got.vec        = {bitangent_z, bitangent_y, bitangent_x,
				tangent_z, tangent_y, tangent_x};
			got.degenerate = degenerate;
			results_seen++;
			if (got.degenerate)
				degenerate_seen++;
			clipped = 1'b0;
			for (k = 0; k < 6; k++)
				if (got.vec[k] == 32'h7fff_ffff || got.vec[k] == 32'h8000_0000)
					clipped = 1'b1;
			if (clipped)
				saturated_seen++;
			if (pending_frames.size() == 0) begin
				flag_error("result transfer with no triangle pending", '0, got.vec[0]);
			end else begin
				want = pending_frames.pop_front();
				for (k = 0; k < 6; k++)
					if (got.vec[k] !== want.vec[k])
						flag_error($sformatf("%s component %0d",
							k < 3 ? "tangent" : "bitangent", k % 3),
							want.vec[k], got.vec[k]);
				if (got.degenerate !== want.degenerate)
					flag_error("degenerate flag", 32'(want.degenerate),
						32'(got.degenerate));
			end
		end
	end

	initial begin
		int target;
		int phase;
		int i;
		arst_n    = 1'b0;
		vtx_valid = 1'b0;
		corner    = CORNER_FIRST;
		pos_x     = '0;
		pos_y     = '0;
		pos_z     = '0;
		tex_u     = '0;
		tex_v     = '0;
		gap_pct   = 0;
		stall_pct = 0;
		hold_req  = 0;
		hold_left = 0;
		for (i = 0; i < 2; i++) begin
			held_pos[i][0] = '0;
			held_pos[i][1] = '0;
			held_pos[i][2] = '0;
			held_uv[i][0]  = '0;
			held_uv[i][1]  = '0;
		end

		// closing a triangle straight after reset uses zeroed corners
		add_row(CORNER_LAST, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			1'b1, frame_of('0, 1'b1));
		add_row(CORNER_UNUSED, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			1'b0, '0);
		add_row(CORNER_LAST, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
			1'b1, frame_of('0, 1'b1));
		// widest edge over a unit determinant: clip high, then clip low
		add_row(CORNER_FIRST, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000,
			1'b0, '0);
		add_row(CORNER_SECOND, 16'h7fff, 16'h8000, 16'h8000, 16'h0001, 16'h0000,
			1'b0, '0);
		add_row(CORNER_LAST, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0001,
			1'b1, frame_of(32'h7fff_ffff, 1'b0));
		add_row(CORNER_SECOND, 16'h7fff, 16'h8000, 16'h8000, 16'hffff, 16'h0000,
			1'b0, '0);
		add_row(CORNER_LAST, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0001,
			1'b1, frame_of(32'h8000_0000, 1'b0));
		// unit right triangle, then a second close on the same held corners
		add_row(CORNER_FIRST, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			1'b0, '0);
		add_row(CORNER_SECOND, 16'h0100, 16'h0000, 16'h0000, 16'h1000, 16'h0000,
			1'b0, '0);
		add_row(CORNER_LAST, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h1000,
			1'b0, '0);
		add_row(CORNER_LAST, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h1000,
			1'b0, '0);
		// collinear UVs with a nonzero determinant term on each side
		add_row(CORNER_SECOND, 16'd100, 16'd200, 16'd300, 16'h1000, 16'h1000,
			1'b0, '0);
		add_row(CORNER_LAST, 16'd7, 16'd8, 16'd9, 16'h2000, 16'h2000,
			1'b1, frame_of('0, 1'b1));
		// texture coordinate extremes
		add_row(CORNER_FIRST, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
			1'b0, '0);
		add_row(CORNER_SECOND, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
			1'b0, '0);
		add_row(CORNER_LAST, 16'h0000, 16'h7fff, 16'hffff, 16'h8000, 16'h7fff,
			1'b0, '0);
		// rounding ties: tangent x lands on +0.5 and -0.5 LSB
		add_row(CORNER_FIRST, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			1'b0, '0);
		add_row(CORNER_SECOND, 16'h0000, 16'h0000, 16'h0000, 16'h0800, 16'h0001,
			1'b0, '0);
		add_row(CORNER_LAST, 16'hfffe, 16'h0000, 16'h0000, 16'h0000, 16'h0800,
			1'b0, '0);
		add_row(CORNER_LAST, 16'h0002, 16'h0000, 16'h0000, 16'h0000, 16'h0800,
			1'b0, '0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < stim_rows.size(); i++)
			take_vertex(stim_rows[i].vtx, stim_rows[i].typed, stim_rows[i].want);

		// hold the result channel off so the vertex channel backs up
		hold_req = HOLD_CYCLES;
		repeat (4) send_triangle();
		// drop valid while waiting so the last corner is not taken twice
		@(negedge clk);
		vtx_valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);

		target = vertices_taken;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 56; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 56; end
				default: begin gap_pct = 17; stall_pct = 17; end
			endcase
			target += RANDOM_ITEMS / 4;
			while (vertices_taken < target) begin
				if ($urandom_range(99) < 12)
					take_vertex(random_vertex(2'($urandom_range(3)), $urandom_range(1)),
						1'b0, '0);
				else
					send_triangle();
			end
		end
		@(negedge clk);
		vtx_valid <= 1'b0;

		while (pending_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d corners plus %0d dropped corner-3 transfers; %0d results checked",
			vertices_taken, drops_taken, results_seen);
		$display("(%0d degenerate, %0d clipped) under four idling mixes and a %0d-cycle hold-off.",
			degenerate_seen, saturated_seen, HOLD_CYCLES);
		if (mismatches == 0)
			$display("** triangle_tangent_basis: PASSED **");
		else
			$display("** triangle_tangent_basis: FAILED **");
		$finish;
	end

endmodule

// ----- triangle_tangent_basis.f -----
hdl/ttb_pkg.sv
hdl/ttb_mac.sv
hdl/ttb_div.sv
hdl/triangle_tangent_basis.sv
hdl/ttb_chk.sv
sim/triangle_tangent_basis_tb.sv
